FILE: sv/bbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants of the buffer cache tag table
// Entry layout, request and status codes, controller states and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int NUM_BUFFERS = 32;
    localparam int IDX_W       = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

    localparam logic [7:0] REFS_MAX = ~8'd0;

    typedef enum logic [1:0]
    {
        OP_READ    = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } op_t;

    typedef enum logic [1:0]
    {
        ST_OK     = 2'd0,
        ST_NEW    = 2'd1,
        ST_NOFREE = 2'd2,
        ST_ERR    = 2'd3
    } status_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SCAN,
        S_SINGLE,
        S_EVAL,
        S_COMMIT
    } state_t;

    typedef struct packed
    {
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [7:0]  refs;
        logic [31:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed
    {
        logic load;
        logic scan_rd;
        logic single_rd;
        logic commit;
    } cmd_t;

    typedef struct packed
    {
        logic scan_last;
        logic out_busy;
    } stat_t;

endpackage

FILE: sv/bbc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

FILE: sv/bbc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_ctrl: request sequencer
// Accepts a request, runs a full table scan for reads or a single entry
// fetch otherwise, then commits the update and result.
// ----------------------------------------------------------------------------
module bbc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  bbc_pkg::op_t  op,
    output bbc_pkg::cmd_t cmd,
    input  bbc_pkg::stat_t stat
);
    import bbc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (op == OP_READ) ? S_SCAN : S_SINGLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_EVAL;
                end
            end
            S_SINGLE:
            begin
                cmd.single_rd = 1'b1;
                state_next    = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/bbc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_datapath: tag table storage, scan tracking and result register
// Holds the entry RAM with valid and filled bits, tracks first hit and
// oldest free entry during a scan, and forms the update and result.
// ----------------------------------------------------------------------------
module bbc_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [79:0]    s_tdata,   // dev, block_number, entry_index, now_tick, pad
    input  bbc_pkg::op_t   s_tuser,   // op
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [15:0]    m_tdata,   // result_index, status, needs_fill, ref_count
    input  bbc_pkg::cmd_t  cmd,
    output bbc_pkg::stat_t stat
);
    import bbc_pkg::*;

    op_t              req_op_reg;
    logic [7:0]       req_dev_reg;
    logic [31:0]      req_blk_reg;
    logic [4:0]       req_idx_reg;
    logic [31:0]      req_now_reg;

    logic [IDX_W-1:0] cnt_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    logic [NUM_BUFFERS-1:0] valid_reg;
    logic [NUM_BUFFERS-1:0] filled_reg;

    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [7:0]       hit_refs_reg;
    logic [31:0]      hit_stamp_reg;
    logic             have_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [31:0]      best_stamp_reg;
    entry_t           cur_reg;

    logic             out_valid_reg;
    logic [4:0]       out_idx_reg;
    status_t          out_st_reg;
    logic             out_fill_reg;
    logic [7:0]       out_refs_reg;

    logic [IDX_W-1:0]   raddr;
    logic [ENTRY_W-1:0] rdata;
    entry_t             ent;
    logic               is_read;
    logic               hit_take;
    logic               vic_take;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    entry_t             wr_ent;
    logic               wr_fill;
    logic [4:0]         res_idx;
    status_t            res_st;
    logic               res_fill;
    logic [7:0]         res_refs;
    logic [7:0]         r_dec;

    bbc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BUFFERS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_idx),
        .wdata (wr_ent),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign raddr   = cmd.single_rd ? IDX_W'(req_idx_reg) : cnt_reg;
    assign ent     = valid_reg[pend_idx_reg] ? entry_t'(rdata) : '0;
    assign is_read = (req_op_reg == OP_READ);

    assign hit_take = pend_reg && is_read && !hit_reg
                      && (ent.dev == req_dev_reg) && (ent.blk == req_blk_reg);
    assign vic_take = pend_reg && is_read && (ent.refs == 8'd0)
                      && (!have_reg || (ent.stamp < best_stamp_reg));

    assign stat.scan_last = (cnt_reg == IDX_W'(NUM_BUFFERS - 1));
    assign stat.out_busy  = out_valid_reg && !m_tready;

    assign r_dec = cur_reg.refs - 8'd1;

    always_comb
    begin
        wr_en    = 1'b0;
        wr_idx   = IDX_W'(req_idx_reg);
        wr_ent   = cur_reg;
        wr_fill  = 1'b0;
        res_idx  = req_idx_reg;
        res_st   = ST_OK;
        res_fill = 1'b0;
        res_refs = 8'd0;
        if (is_read)
        begin
            if (hit_reg)
            begin
                res_idx = 5'(hit_idx_reg);
                wr_idx  = hit_idx_reg;
                if (hit_refs_reg == REFS_MAX)
                begin
                    res_st   = ST_ERR;
                    res_refs = REFS_MAX;
                end
                else
                begin
                    wr_en    = cmd.commit;
                    wr_fill  = cmd.commit;
                    wr_ent   = '{dev: req_dev_reg, blk: req_blk_reg,
                                 refs: hit_refs_reg + 8'd1, stamp: hit_stamp_reg};
                    res_fill = !filled_reg[hit_idx_reg];
                    res_refs = hit_refs_reg + 8'd1;
                end
            end
            else if (have_reg)
            begin
                res_idx  = 5'(best_idx_reg);
                res_st   = ST_NEW;
                res_fill = 1'b1;
                res_refs = 8'd1;
                wr_idx   = best_idx_reg;
                wr_en    = cmd.commit;
                wr_fill  = cmd.commit;
                wr_ent   = '{dev: req_dev_reg, blk: req_blk_reg,
                             refs: 8'd1, stamp: best_stamp_reg};
            end
            else
            begin
                res_idx = 5'd0;
                res_st  = ST_NOFREE;
            end
        end
        else if (32'(req_idx_reg) >= NUM_BUFFERS)
        begin
            res_st = ST_ERR;
        end
        else if (req_op_reg == OP_PIN)
        begin
            if (cur_reg.refs == REFS_MAX)
            begin
                res_st   = ST_ERR;
                res_refs = REFS_MAX;
            end
            else
            begin
                wr_en       = cmd.commit;
                wr_ent.refs = cur_reg.refs + 8'd1;
                res_refs    = cur_reg.refs + 8'd1;
            end
        end
        else
        begin
            if (cur_reg.refs == 8'd0)
            begin
                res_st = ST_ERR;
            end
            else
            begin
                wr_en       = cmd.commit;
                wr_ent.refs = r_dec;
                res_refs    = r_dec;
                if ((req_op_reg == OP_RELEASE) && (r_dec == 8'd0))
                begin
                    wr_ent.stamp = req_now_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            valid_reg     <= '0;
            filled_reg    <= '0;
            hit_reg       <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.scan_rd || cmd.single_rd;
            if (cmd.load)
            begin
                cnt_reg  <= '0;
                hit_reg  <= 1'b0;
                have_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_rd)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (hit_take)
                begin
                    hit_reg <= 1'b1;
                end
                if (vic_take)
                begin
                    have_reg <= 1'b1;
                end
            end
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (wr_fill)
            begin
                filled_reg[wr_idx] <= 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_op_reg  <= s_tuser;
            req_dev_reg <= s_tdata[7:0];
            req_blk_reg <= s_tdata[39:8];
            req_idx_reg <= s_tdata[44:40];
            req_now_reg <= s_tdata[76:45];
        end
        if (cmd.scan_rd || cmd.single_rd)
        begin
            pend_idx_reg <= raddr;
        end
        if (pend_reg)
        begin
            cur_reg <= ent;
        end
        if (hit_take)
        begin
            hit_idx_reg   <= pend_idx_reg;
            hit_refs_reg  <= ent.refs;
            hit_stamp_reg <= ent.stamp;
        end
        if (vic_take)
        begin
            best_idx_reg   <= pend_idx_reg;
            best_stamp_reg <= ent.stamp;
        end
        if (cmd.commit)
        begin
            out_idx_reg  <= res_idx;
            out_st_reg   <= res_st;
            out_fill_reg <= res_fill;
            out_refs_reg <= res_refs;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_refs_reg, out_fill_reg, out_st_reg, out_idx_reg};

    // commit never overwrites a result still waiting downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && !m_tready))
        else $error("commit while result pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit did not raise result valid");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && !is_read) |-> (pend_idx_reg == IDX_W'(req_idx_reg)))
        else $error("single fetch used wrong entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (cmd.commit && !pend_reg))
        else $error("table write outside commit");

endmodule

FILE: sv/block_buffer_cache_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_buffer_cache_lru: buffer cache tag table with LRU replacement
// Reference-counted tag table; reads look up or allocate, release/pin/unpin
// adjust counts.
// ----------------------------------------------------------------------------
// One request at a time. A read scans every entry through the single read
// port of the tag RAM, one entry per cycle, to find the lowest matching tag
// and the oldest unreferenced entry. Release, pin and unpin fetch one entry.
// The result sits in an output register, so a new request is taken the cycle
// after the previous one has committed. Commit waits while a prior result is
// still not taken. Table state is zero after reset through per-entry valid
// bits, with no clearing pass.
module block_buffer_cache_lru (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [79:0]   s_tdata,   // dev[7:0], block_number[39:8], entry_index[44:40],
                                     // now_tick[76:45], zero pad
    input  logic [1:0]    s_tuser,   // op[1:0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_tdata    // result_index[4:0], status[6:5], needs_fill[7],
                                     // ref_count[15:8]
);
    import bbc_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    op_t   op;

    assign op = op_t'(s_tuser);

    bbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (op),
        .cmd      (cmd),
        .stat     (stat)
    );

    bbc_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the buffer cache tag table
// Streams read/release/pin/unpin requests into the block and checks every
// response against an in-bench model of the tag table. A directed opening
// covers the corner cases. Random traffic follows: mixed requests over a
// small tag pool, table fill-ups to exhaustion with drains, and one count
// driven to saturation. Both stream sides stall at random, bar the last third.
// ----------------------------------------------------------------------------
module testbench;
    import bbc_pkg::*;

    localparam int ITEM_TARGET    = 650;
    localparam int POOL_SIZE      = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed
    {
        op_t         op;
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [4:0]  idx;
        logic [31:0] tick;
    } req_t;

    // matches m_tdata from the lowest bit up: index, status, fill, count
    typedef struct packed
    {
        logic [7:0] refs;
        logic       fill;
        status_t    st;
        logic [4:0] idx;
    } resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;   // dev, block_number, entry_index, now_tick, zero pad
    logic [1:0]  s_tuser = '0;   // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // result_index, status, needs_fill, ref_count

    // tag table as the block should hold it
    logic [7:0]  tag_dev    [NUM_BUFFERS];
    logic [31:0] tag_blk    [NUM_BUFFERS];
    logic [7:0]  tag_refs   [NUM_BUFFERS];
    logic [31:0] tag_stamp  [NUM_BUFFERS];
    logic        tag_filled [NUM_BUFFERS];

    req_t  req_q[$];
    resp_t owed_responses[$];
    req_t  bus_req;

    logic [7:0]  pool_dev [POOL_SIZE];
    logic [31:0] pool_blk [POOL_SIZE];
    logic [31:0] sys_tick = '0;

    int issued = 0;
    int idle_pct = 18;
    int stall_pct = 61;
    int error_cnt = 0;
    int quiet_cycles = 0;

    block_buffer_cache_lru uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < NUM_BUFFERS; i++)
        begin
            tag_dev[i]    = '0;
            tag_blk[i]    = '0;
            tag_refs[i]   = '0;
            tag_stamp[i]  = '0;
            tag_filled[i] = 1'b0;
        end
    end

    // apply one request to the table copy and return the response it owes
    function automatic resp_t apply_request(req_t r);
        resp_t rsp;
        int hit;
        int victim;
        int slot;
        logic [7:0] cnt;
        rsp = '0;
        if (r.op == OP_READ)
        begin
            hit = -1;
            for (int i = 0; i < NUM_BUFFERS; i++)
                if (hit < 0 && tag_dev[i] == r.dev && tag_blk[i] == r.blk)
                    hit = i;
            if (hit >= 0)
            begin
                rsp.idx = 5'(hit);
                if (tag_refs[hit] == REFS_MAX)
                begin
                    rsp.st   = ST_ERR;
                    rsp.refs = REFS_MAX;
                end
                else
                begin
                    tag_refs[hit]   = tag_refs[hit] + 8'd1;
                    rsp.fill        = !tag_filled[hit];
                    tag_filled[hit] = 1'b1;
                    rsp.st          = ST_OK;
                    rsp.refs        = tag_refs[hit];
                end
            end
            else
            begin
                victim = -1;
                for (int i = 0; i < NUM_BUFFERS; i++)
                    if (tag_refs[i] == 0 && (victim < 0 || tag_stamp[i] < tag_stamp[victim]))
                        victim = i;
                if (victim < 0)
                    rsp.st = ST_NOFREE;
                else
                begin
                    tag_dev[victim]    = r.dev;
                    tag_blk[victim]    = r.blk;
                    tag_refs[victim]   = 8'd1;
                    tag_filled[victim] = 1'b1;
                    rsp.idx  = 5'(victim);
                    rsp.st   = ST_NEW;
                    rsp.fill = 1'b1;
                    rsp.refs = 8'd1;
                end
            end
        end
        else if (int'(r.idx) >= NUM_BUFFERS)
        begin
            rsp.idx = r.idx;
            rsp.st  = ST_ERR;
        end
        else
        begin
            slot    = int'(r.idx);
            cnt     = tag_refs[slot];
            rsp.idx = r.idx;
            if (r.op == OP_PIN && cnt == REFS_MAX)
            begin
                rsp.st   = ST_ERR;
                rsp.refs = cnt;
            end
            else if (r.op != OP_PIN && cnt == 0)
                rsp.st = ST_ERR;
            else
            begin
                if (r.op == OP_PIN)
                    cnt = cnt + 8'd1;
                else
                begin
                    cnt = cnt - 8'd1;
                    // only a release back to zero stamps the entry
                    if (r.op == OP_RELEASE && cnt == 0)
                        tag_stamp[slot] = r.tick;
                end
                tag_refs[slot] = cnt;
                rsp.st   = ST_OK;
                rsp.refs = cnt;
            end
        end
        return rsp;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                owed_responses.push_back(apply_request(bus_req));
            if (!s_tvalid || s_tready)
            begin
                if (req_q.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    bus_req = req_q.pop_front();
                    s_tdata  <= {3'b000, bus_req.tick, bus_req.idx, bus_req.blk, bus_req.dev};
                    s_tuser  <= bus_req.op;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        resp_t got;
        resp_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
            if (m_tvalid && m_tready)
            begin
                got = resp_t'(m_tdata);
                if (owed_responses.size() == 0)
                begin
                    error_cnt++;
                    if (error_cnt <= MAX_REPORTS)
                        $display("unexpected response: idx %0d st %0d fill %0d refs %0d",
                                 got.idx, got.st, got.fill, got.refs);
                end
                else
                begin
                    want = owed_responses.pop_front();
                    if (got.idx !== want.idx || got.st !== want.st ||
                        got.fill !== want.fill || got.refs !== want.refs)
                    begin
                        error_cnt++;
                        if (error_cnt <= MAX_REPORTS)
                            $display("mismatch: exp idx %0d st %0d fill %0d refs %0d, got idx %0d st %0d fill %0d refs %0d",
                                     want.idx, want.st, want.fill, want.refs,
                                     got.idx, got.st, got.fill, got.refs);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("block_buffer_cache_lru verification failed");
                $finish;
            end
        end
    end

    // one request in flight at a time, so choices below see the current table
    task automatic issue(op_t op, logic [7:0] dev, logic [31:0] blk,
                         logic [4:0] idx, logic [31:0] tick);
        req_t r;
        do @(negedge clk); while (req_q.size() != 0 || s_tvalid);
        if (issued < ITEM_TARGET / 3)
        begin
            idle_pct  = 18;
            stall_pct = 61;
        end
        else if (issued < 2 * ITEM_TARGET / 3)
        begin
            idle_pct  = 61;
            stall_pct = 18;
        end
        else
        begin
            idle_pct  = 0;
            stall_pct = 0;
        end
        r.op   = op;
        r.dev  = dev;
        r.blk  = blk;
        r.idx  = idx;
        r.tick = tick;
        req_q.push_back(r);
        issued++;
    endtask

    function automatic logic [31:0] next_tick();
        case ($urandom_range(9))
            0: sys_tick = $urandom;
            1: sys_tick = 32'hFFFF_FFFF;
            2: sys_tick = 32'h0;
            3: ;
            default: sys_tick = sys_tick + 32'($urandom_range(1, 1000));
        endcase
        return sys_tick;
    endfunction

    function automatic logic [4:0] busy_entry();
        int start;
        start = $urandom_range(NUM_BUFFERS - 1);
        for (int k = 0; k < NUM_BUFFERS; k++)
            if (tag_refs[(start + k) % NUM_BUFFERS] != 0)
                return 5'((start + k) % NUM_BUFFERS);
        return 5'(start);
    endfunction

    function automatic bit table_has_free();
        for (int i = 0; i < NUM_BUFFERS; i++)
            if (tag_refs[i] == 0)
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic read_pool();
        int p;
        p = $urandom_range(POOL_SIZE - 1);
        issue(OP_READ, pool_dev[p], pool_blk[p], 5'($urandom), $urandom);
    endtask

    task automatic fill_and_drain();
        logic [31:0] t;
        while (table_has_free())
            issue(OP_READ, 8'($urandom), $urandom, 5'($urandom), $urandom);
        issue(OP_READ, 8'($urandom), $urandom, 5'($urandom), $urandom);
        read_pool();
        t = next_tick();
        for (int i = 0; i < NUM_BUFFERS; i++)
            while (tag_refs[i] != 0 && tag_refs[i] < 8)
            begin
                if ($urandom_range(2) != 0)
                    t = next_tick();
                issue(OP_RELEASE, 8'($urandom), $urandom, 5'(i), t);
            end
    endtask

    task automatic saturate_entry();
        logic [4:0] e;
        e = 5'($urandom_range(NUM_BUFFERS - 1));
        while (tag_refs[e] != REFS_MAX)
            issue(OP_PIN, 8'($urandom), $urandom, e, $urandom);
        issue(OP_PIN, 8'($urandom), $urandom, e, $urandom);
        issue(OP_READ, tag_dev[e], tag_blk[e], 5'($urandom), $urandom);
        issue(OP_UNPIN, 8'($urandom), $urandom, e, $urandom);
        issue(OP_PIN, 8'($urandom), $urandom, e, $urandom);
    endtask

    task automatic mixed_request();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            read_pool();
        else if (sel < 45)
            issue(OP_READ, 8'($urandom), $urandom, 5'($urandom), $urandom);
        else if (sel < 70)
            issue(OP_RELEASE, 8'($urandom), $urandom, busy_entry(), next_tick());
        else if (sel < 80)
            issue(OP_PIN, 8'($urandom), $urandom,
                  $urandom_range(1) ? busy_entry() : 5'($urandom), $urandom);
        else if (sel < 90)
            issue(OP_UNPIN, 8'($urandom), $urandom, busy_entry(), $urandom);
        else
            issue(op_t'($urandom_range(3)), 8'($urandom), $urandom, 5'($urandom), next_tick());
    endtask

    initial
    begin
        bit saturated;
        int burst_cnt;
        saturated = 1'b0;
        burst_cnt = 0;
        pool_dev[0] = 8'h00; pool_blk[0] = 32'h0000_0000;
        pool_dev[1] = 8'hFF; pool_blk[1] = 32'hFFFF_FFFF;
        pool_dev[2] = 8'h00; pool_blk[2] = 32'hFFFF_FFFF;
        pool_dev[3] = 8'hFF; pool_blk[3] = 32'h0000_0000;
        for (int p = 4; p < POOL_SIZE; p++)
        begin
            pool_dev[p] = 8'($urandom_range(3));
            pool_blk[p] = ($urandom_range(1) != 0) ? 32'($urandom_range(15)) : $urandom;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // after reset every entry is tagged (0,0) and unfilled
        issue(OP_READ, 8'h00, 32'h0000_0000, 5'd31, 32'h0);
        issue(OP_READ, 8'h00, 32'h0000_0000, 5'd0, 32'hFFFF_FFFF);
        issue(OP_READ, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'h0);
        issue(OP_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'hFFFF_FFFF);
        issue(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0, 32'hFFFF_FFFF);
        issue(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0, 32'h0000_1234);
        issue(OP_UNPIN, 8'hAA, 32'h5555_5555, 5'd0, 32'h0);
        issue(OP_PIN, 8'h55, 32'hAAAA_AAAA, 5'd31, 32'h0);
        issue(OP_UNPIN, 8'h00, 32'h0000_0000, 5'd31, 32'hFFFF_FFFF);
        issue(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd1, 32'h0);
        issue(OP_READ, 8'h01, 32'h8000_0000, 5'd0, 32'h0);
        issue(OP_READ, 8'h00, 32'h0000_0000, 5'd0, 32'h0);
        issue(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0, 32'h0);
        issue(OP_READ, 8'h07, 32'h1234_5678, 5'd0, 32'h0);
        issue(OP_READ, 8'h00, 32'h0000_0000, 5'd0, 32'h0);
        issue(OP_PIN, 8'h00, 32'h0000_0000, 5'd2, 32'h0);
        issue(OP_UNPIN, 8'h00, 32'h0000_0000, 5'd2, 32'h0);

        while (issued < ITEM_TARGET)
        begin
            if ((burst_cnt == 0 && issued >= 120) || (burst_cnt == 1 && issued >= 480))
            begin
                fill_and_drain();
                burst_cnt++;
            end
            else if (!saturated && issued >= 250)
            begin
                saturate_entry();
                saturated = 1'b1;
            end
            else
                mixed_request();
        end

        do @(negedge clk); while (req_q.size() != 0 || s_tvalid || owed_responses.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        error_cnt += owed_responses.size();
        if (error_cnt == 0)
            $display("block_buffer_cache_lru verification clean");
        else
            $display("block_buffer_cache_lru verification failed");
        $finish;
    end

endmodule
